// ===== src/one_wire_bus_master_unit_assert.svh =====
// Assertion macros used by the port-level checker of the bus master.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OWBM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/owbm_pkg.sv =====
// Shared types, codes, timing constants and helper functions of the bus master.
package owbm_pkg;

	localparam int unsigned TICK_W = 10;
	localparam int unsigned NUM_REGS = 8;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_RESET = 3'd1;
	localparam logic [2:0] CMD_WBIT  = 3'd2;
	localparam logic [2:0] CMD_RBIT  = 3'd3;
	localparam logic [2:0] CMD_WBYTE = 3'd4;
	localparam logic [2:0] CMD_RBYTE = 3'd5;
	localparam logic [2:0] CMD_TOUCH = 3'd6;

	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_RST_PRE    = 4'd1;
	localparam logic [3:0] PH_RST_LOW    = 4'd2;
	localparam logic [3:0] PH_RST_WAIT   = 4'd3;
	localparam logic [3:0] PH_RST_REC    = 4'd4;
	localparam logic [3:0] PH_SLOT_LOW   = 4'd5;
	localparam logic [3:0] PH_WRITE_REST = 4'd6;
	localparam logic [3:0] PH_READ_WAIT  = 4'd7;
	localparam logic [3:0] PH_READ_REST  = 4'd8;

	localparam logic [2:0] REG_SHORT_LOW     = 3'd0;
	localparam logic [2:0] REG_W1_REST       = 3'd1;
	localparam logic [2:0] REG_LONG_LOW      = 3'd2;
	localparam logic [2:0] REG_W0_REST       = 3'd3;
	localparam logic [2:0] REG_SAMPLE_DELAY  = 3'd4;
	localparam logic [2:0] REG_READ_REST     = 3'd5;
	localparam logic [2:0] REG_RESET_LOW     = 3'd6;
	localparam logic [2:0] REG_PRESENCE_WAIT = 3'd7;

	localparam logic [TICK_W-1:0] RESET_PRE_TICKS      = 10'd0;
	localparam logic [TICK_W-1:0] RESET_RECOVERY_TICKS = 10'd410;

	localparam logic [TICK_W-1:0] REG_RESET_VAL [NUM_REGS] = '{
		10'd6, 10'd64, 10'd60, 10'd10, 10'd9, 10'd55, 10'd480, 10'd70
	};

	typedef logic [TICK_W-1:0] tick_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data;
		logic       line;
	} req_t;

	function automatic tick_t dur(input tick_t v);
		return (v == '0) ? tick_t'(1) : v;
	endfunction

	function automatic logic slot_reads(input logic [2:0] cmd, input logic s0);
		return (cmd == CMD_RBIT) || (cmd == CMD_RBYTE) || ((cmd == CMD_TOUCH) && s0);
	endfunction

	function automatic tick_t slot_low(input logic [2:0] cmd, input logic s0,
			input tick_t short_t, input tick_t long_t);
		return (slot_reads(cmd, s0) || s0) ? dur(short_t) : dur(long_t);
	endfunction

endpackage

// ===== src/owbm_front.sv =====
// Front end: accepts tick requests, decodes the command and queues them.
module owbm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [2:0]     operation,
	input  logic [7:0]     data_byte,
	input  logic           line_level,
	output logic           head_valid,
	output owbm_pkg::req_t head,
	input  logic           pop
);
	import owbm_pkg::*;

	logic [1:0] count_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	req_t       entry0_q;
	req_t       entry1_q;
	req_t       decoded;
	logic       push;

	always_comb begin
		decoded.cmd  = (operation >= CMD_RESET && operation <= CMD_TOUCH) ? operation : CMD_NONE;
		decoded.data = data_byte;
		decoded.line = line_level;
	end

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = rd_ptr_q ? entry1_q : entry0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !wr_ptr_q)
			entry0_q <= decoded;
		if (push && wr_ptr_q)
			entry1_q <= decoded;
	end

endmodule

// ===== src/owbm_back.sv =====
// Back end: slot timing state machine, timing registers and result register.
module owbm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [2:0]     wr_index,
	input  logic [9:0]     wr_data,
	input  logic           head_valid,
	input  owbm_pkg::req_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           drive_low,
	output logic           busy_res,
	output logic           done_res,
	output logic [7:0]     read_data,
	output logic           presence
);
	import owbm_pkg::*;

	tick_t      cfg_q [NUM_REGS];
	logic [3:0] phase_q;
	tick_t      tick_q;
	logic [3:0] bits_q;
	logic [7:0] send_q;
	logic [7:0] recv_q;
	logic [2:0] cmd_q;
	logic       pres_q;
	logic       out_valid_q;

	logic [3:0] ph;
	tick_t      tc;
	logic [3:0] bl;
	logic [7:0] ss;
	logic [7:0] rs;
	logic [2:0] ac;
	logic       pf;
	logic       fin;
	logic       drv;
	logic       bsy;

	assign pop = head_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		ph  = phase_q;
		tc  = tick_q;
		bl  = bits_q;
		ss  = send_q;
		rs  = recv_q;
		ac  = cmd_q;
		pf  = pres_q;
		fin = 1'b0;
		if (phase_q == PH_IDLE && head.cmd != CMD_NONE) begin
			ac = head.cmd;
			rs = 8'd0;
			if (ac == CMD_RESET) begin
				if (RESET_PRE_TICKS != '0) begin
					ph = PH_RST_PRE;
					tc = RESET_PRE_TICKS;
				end else begin
					ph = PH_RST_LOW;
					tc = dur(cfg_q[REG_RESET_LOW]);
				end
			end else begin
				bl = (ac == CMD_WBIT || ac == CMD_RBIT) ? 4'd1 : 4'd8;
				ss = (ac == CMD_WBIT) ? {7'd0, head.data[0]} : head.data;
				ph = PH_SLOT_LOW;
				tc = slot_low(ac, ss[0], cfg_q[REG_SHORT_LOW], cfg_q[REG_LONG_LOW]);
			end
		end
		drv = (ph == PH_RST_LOW) || (ph == PH_SLOT_LOW);
		bsy = (ph != PH_IDLE);
		if (bsy) begin
			tc = tc - tick_t'(1);
			if (tc == '0) begin
				case (ph)
					PH_RST_PRE: begin
						ph = PH_RST_LOW;
						tc = dur(cfg_q[REG_RESET_LOW]);
					end
					PH_RST_LOW: begin
						ph = PH_RST_WAIT;
						tc = dur(cfg_q[REG_PRESENCE_WAIT]);
					end
					PH_RST_WAIT: begin
						pf = ~head.line;
						ph = PH_RST_REC;
						tc = dur(RESET_RECOVERY_TICKS);
					end
					PH_SLOT_LOW: begin
						if (slot_reads(ac, ss[0])) begin
							ph = PH_READ_WAIT;
							tc = dur(cfg_q[REG_SAMPLE_DELAY]);
						end else begin
							ph = PH_WRITE_REST;
							tc = ss[0] ? dur(cfg_q[REG_W1_REST]) : dur(cfg_q[REG_W0_REST]);
						end
					end
					PH_READ_WAIT: begin
						rs = (ac == CMD_RBIT) ? {7'd0, head.line} : (rs | {head.line, 7'd0});
						ph = PH_READ_REST;
						tc = dur(cfg_q[REG_READ_REST]);
					end
					PH_WRITE_REST, PH_READ_REST: begin
						ss = ss >> 1;
						if (bl <= 4'd1) begin
							bl  = 4'd0;
							ph  = PH_IDLE;
							tc  = '0;
							fin = 1'b1;
						end else begin
							bl = bl - 4'd1;
							if (ac == CMD_RBYTE || ac == CMD_TOUCH)
								rs = rs >> 1;
							ph = PH_SLOT_LOW;
							tc = slot_low(ac, ss[0], cfg_q[REG_SHORT_LOW], cfg_q[REG_LONG_LOW]);
						end
					end
					default: begin
						ph  = PH_IDLE;
						tc  = '0;
						fin = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				cfg_q[i] <= REG_RESET_VAL[i];
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bits_q      <= 4'd0;
			send_q      <= 8'd0;
			recv_q      <= 8'd0;
			cmd_q       <= CMD_NONE;
			pres_q      <= 1'b0;
			out_valid_q <= 1'b0;
			drive_low   <= 1'b0;
			busy_res    <= 1'b0;
			done_res    <= 1'b0;
			read_data   <= 8'd0;
			presence    <= 1'b0;
		end else begin
			if (wr_en)
				cfg_q[wr_index] <= wr_data;
			if (pop) begin
				phase_q   <= ph;
				tick_q    <= tc;
				bits_q    <= bl;
				send_q    <= ss;
				recv_q    <= rs;
				cmd_q     <= ac;
				pres_q    <= pf;
				drive_low <= drv;
				busy_res  <= bsy;
				done_res  <= fin;
				read_data <= rs;
				presence  <= pf;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/one_wire_bus_master_unit.sv =====
// Top level of the one-wire bus master: request queue front end and slot timing back end.
// A tick request is registered in the request queue, then in the result register.
// Throughput: one tick request per cycle while the result register is not stalled.
// The two-entry request queue takes requests while the back end stalls, until it is full.
// Reset: arst_n is asynchronous and active low; it restores the default slot timings,
// idles the bus, clears read data and presence, and empties the queue and result register.
module one_wire_bus_master_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [9:0] wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] data_byte,
	input  logic       line_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       drive_low,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] read_data,
	output logic       presence
);
	import owbm_pkg::*;

	logic head_valid;
	req_t head;
	logic pop;

	owbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.data_byte  (data_byte),
		.line_level (line_level),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	owbm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.drive_low  (drive_low),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data),
		.presence   (presence)
	);

endmodule

// ===== src/owbm_checker.sv =====
// Port-level checker of the bus master, bound to the top level.
`include "one_wire_bus_master_unit_assert.svh"

module owbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       drive_low,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data
);

	`OWBM_ASSERT_NOW(a_idle_quiet, out_valid && !busy_res, !drive_low && !done_res, "idle tick drives bus or completes")
	`OWBM_ASSERT_NOW(a_done_released, out_valid && done_res, !drive_low, "bus still driven low on completing tick")
	`OWBM_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(read_data) && $stable(drive_low), "stalled result changed")

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);

// ===== bench/owbm_tick_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bus master: tracks timing writes, predicts every tick result and compares.
module owbm_tick_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [9:0] wr_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] data_byte,
	input  logic       line_level,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       drive_low,
	input  logic       busy_res,
	input  logic       done_res,
	input  logic [7:0] read_data,
	input  logic       presence,
	output int         mismatches,
	output int         ticks_due,
	output logic       bus_idle
);
	import owbm_pkg::*;

	typedef struct packed {
		logic       drive;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
		logic       pres;
	} bus_tick_t;

	bus_tick_t due_ticks [$];

	tick_t      timing [NUM_REGS];
	logic [3:0] ph;
	tick_t      cnt;
	logic [3:0] bits;
	logic [7:0] tx_sr;
	logic [7:0] rx_sr;
	logic [2:0] cmd;
	logic       pres_q;

	function automatic tick_t span(input tick_t v);
		return (v == '0) ? tick_t'(1) : v;
	endfunction

	function automatic logic sampling_slot();
		if (cmd == CMD_RBIT || cmd == CMD_RBYTE) begin
			return 1'b1;
		end
		if (cmd == CMD_TOUCH) begin
			return tx_sr[0];
		end
		return 1'b0;
	endfunction

	function automatic void open_slot();
		if (cmd == CMD_RBYTE || cmd == CMD_TOUCH) begin
			rx_sr = rx_sr >> 1;
		end
		ph = PH_SLOT_LOW;
		if (sampling_slot() || tx_sr[0]) begin
			cnt = span(timing[REG_SHORT_LOW]);
		end else begin
			cnt = span(timing[REG_LONG_LOW]);
		end
	endfunction

	function automatic bus_tick_t advance_bus_tick(input logic [2:0] op, input logic [7:0] d,
			input logic ln);
		bus_tick_t r;
		logic      fin;
		fin = 1'b0;
		if (ph == PH_IDLE && op >= CMD_RESET && op <= CMD_TOUCH) begin
			cmd = op;
			rx_sr = '0;
			if (op == CMD_RESET) begin
				if (RESET_PRE_TICKS != '0) begin
					ph = PH_RST_PRE;
					cnt = RESET_PRE_TICKS;
				end else begin
					ph = PH_RST_LOW;
					cnt = span(timing[REG_RESET_LOW]);
				end
			end else begin
				bits = (op == CMD_WBIT || op == CMD_RBIT) ? 4'd1 : 4'd8;
				tx_sr = (op == CMD_WBIT) ? {7'd0, d[0]} : d;
				open_slot();
			end
		end
		r.drive = (ph == PH_RST_LOW || ph == PH_SLOT_LOW);
		r.busy = (ph != PH_IDLE);
		if (r.busy) begin
			cnt = cnt - tick_t'(1);
			if (cnt == '0) begin
				case (ph)
					PH_RST_PRE: begin
						ph = PH_RST_LOW;
						cnt = span(timing[REG_RESET_LOW]);
					end
					PH_RST_LOW: begin
						ph = PH_RST_WAIT;
						cnt = span(timing[REG_PRESENCE_WAIT]);
					end
					PH_RST_WAIT: begin
						pres_q = ~ln;
						ph = PH_RST_REC;
						cnt = span(RESET_RECOVERY_TICKS);
					end
					PH_SLOT_LOW: begin
						if (sampling_slot()) begin
							ph = PH_READ_WAIT;
							cnt = span(timing[REG_SAMPLE_DELAY]);
						end else begin
							ph = PH_WRITE_REST;
							cnt = tx_sr[0] ? span(timing[REG_W1_REST]) : span(timing[REG_W0_REST]);
						end
					end
					PH_READ_WAIT: begin
						if (cmd == CMD_RBIT) begin
							rx_sr = {7'd0, ln};
						end else begin
							rx_sr = rx_sr | {ln, 7'd0};
						end
						ph = PH_READ_REST;
						cnt = span(timing[REG_READ_REST]);
					end
					PH_WRITE_REST, PH_READ_REST: begin
						tx_sr = tx_sr >> 1;
						if (bits <= 4'd1) begin
							bits = '0;
							ph = PH_IDLE;
							cnt = '0;
							fin = 1'b1;
						end else begin
							bits = bits - 4'd1;
							open_slot();
						end
					end
					default: begin
						ph = PH_IDLE;
						cnt = '0;
						fin = 1'b1;
					end
				endcase
			end
		end
		r.done = fin;
		r.rdata = rx_sr;
		r.pres = pres_q;
		return r;
	endfunction

	function automatic void compare_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bus_tick_t want;
		if (!arst_n) begin
			timing = REG_RESET_VAL;
			ph = PH_IDLE;
			cnt = '0;
			bits = '0;
			tx_sr = '0;
			rx_sr = '0;
			cmd = CMD_NONE;
			pres_q = 1'b0;
			due_ticks.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (due_ticks.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, actual drive %0h busy %0h",
						$time, drive_low, busy_res);
				end else begin
					want = due_ticks.pop_front();
					compare_field("drive_low", 8'(want.drive), 8'(drive_low));
					compare_field("busy_res", 8'(want.busy), 8'(busy_res));
					compare_field("done_res", 8'(want.done), 8'(done_res));
					compare_field("read_data", want.rdata, read_data);
					compare_field("presence", 8'(want.pres), 8'(presence));
				end
			end
			if (wr_en) begin
				timing[wr_index] = wr_data;
			end
			if (in_valid && !in_stall) begin
				due_ticks.push_back(advance_bus_tick(operation, data_byte, line_level));
			end
		end
		ticks_due = due_ticks.size();
		bus_idle = (ph == PH_IDLE);
	end

endmodule

// ===== bench/one_wire_bus_master_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: drives tick requests and timing writes into the bus master and gives the verdict.
module one_wire_bus_master_unit_tb;
	import owbm_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int HOLD_AT = 400;
	localparam int HOLD_LEN = 400;
	localparam int LINE_RANDOM = 2;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_TICKS = 100;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       wr_en = 1'b0;
	logic [2:0] wr_index = REG_SHORT_LOW;
	logic [9:0] wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] operation = CMD_NONE;
	logic [7:0] data_byte = '0;
	logic       line_level = 1'b1;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       presence;
	int         chk_fails;
	int         ticks_due;
	logic       bus_idle;
	int         accepted_cnt = 0;
	int         cycle_cnt = 0;
	int         send_calm = 0;
	int         line_mode = LINE_RANDOM;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	one_wire_bus_master_unit u_dut (.*);

	owbm_tick_checker u_chk (.*, .mismatches(chk_fails));

	function automatic int pick_gap(inout int calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (r < 2) begin
			calm = $urandom_range(30, 150);
			return 0;
		end
		if (r < 60) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic line_pick();
		if (line_mode == LINE_RANDOM) begin
			return 1'($urandom_range(0, 1));
		end
		return line_mode[0];
	endfunction

	function automatic logic [2:0] random_command();
		if ($urandom_range(0, 31) == 0) begin
			return CMD_RESET;
		end
		return 3'($urandom_range(CMD_WBIT, CMD_TOUCH));
	endfunction

	task automatic offer(input logic [2:0] op, input logic [7:0] d, input logic ln);
		int gap;
		gap = pick_gap(send_calm);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		data_byte <= d;
		line_level <= ln;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		accepted_cnt++;
		#1;
	endtask

	task automatic finish_busy();
		while (!bus_idle) begin
			offer(3'($urandom_range(CMD_NONE, OP_UNUSED)), 8'($urandom), line_pick());
		end
	endtask

	task automatic issue(input logic [2:0] op, input logic [7:0] d);
		offer(op, d, line_pick());
		finish_busy();
	endtask

	task automatic issue_on_line(input logic [2:0] op, input logic [7:0] d, input logic ln);
		line_mode = int'(ln);
		issue(op, d);
		line_mode = LINE_RANDOM;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (ticks_due == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic reprogram(input tick_t plan [NUM_REGS]);
		finish_busy();
		drain();
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			wr_en <= 1'b1;
			wr_index <= 3'(i);
			wr_data <= plan[i];
			@(posedge clk);
		end
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin : watchdog
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("one_wire_bus_master_unit_tb: FAIL");
		$finish;
	end

	initial begin : result_sink
		int stall_left;
		int sink_calm;
		bit held;
		stall_left = 0;
		sink_calm = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && accepted_cnt >= HOLD_AT) begin
				held = 1'b1;
				stall_left = HOLD_LEN;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap(sink_calm);
			end
		end
	end

	initial begin : stimulus
		tick_t plan [NUM_REGS];
		int phase_end;
		int maxv;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_WBIT, 8'h01);
		issue(CMD_RBIT, 8'h00);

		plan = '{default: tick_t'(1)};
		reprogram(plan);
		issue(CMD_WBIT, 8'hFE);
		issue(CMD_WBIT, 8'hFF);
		offer(OP_UNUSED, 8'hFF, 1'b0);
		offer(CMD_NONE, 8'h00, 1'b1);
		issue_on_line(CMD_RBIT, 8'h00, 1'b1);
		issue_on_line(CMD_RBIT, 8'hFF, 1'b0);
		issue(CMD_WBYTE, 8'h00);
		issue(CMD_WBYTE, 8'hFF);
		issue_on_line(CMD_RBYTE, 8'h00, 1'b1);
		issue(CMD_RBYTE, 8'h5A);
		issue(CMD_TOUCH, 8'hA5);
		issue_on_line(CMD_TOUCH, 8'hFF, 1'b0);
		issue(CMD_TOUCH, 8'h00);
		issue_on_line(CMD_RESET, 8'h00, 1'b1);

		plan = '{default: tick_t'(0)};
		reprogram(plan);
		issue(CMD_WBYTE, 8'h5A);
		issue(CMD_RBYTE, 8'h00);
		issue(CMD_TOUCH, 8'h3C);
		issue_on_line(CMD_RESET, 8'h00, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			maxv = 2 << p;
			for (int r = 0; r < NUM_REGS; r++) begin
				if ($urandom_range(0, 19) == 0) begin
					plan[r] = tick_t'(0);
				end else begin
					plan[r] = tick_t'($urandom_range(1, maxv));
				end
			end
			reprogram(plan);
			phase_end = accepted_cnt + PHASE_TICKS;
			while (accepted_cnt < phase_end) begin
				if (bus_idle && $urandom_range(0, 9) < 7) begin
					offer(random_command(), 8'($urandom), line_pick());
				end else if (bus_idle) begin
					offer(($urandom_range(0, 1) != 0) ? OP_UNUSED : CMD_NONE, 8'($urandom),
						line_pick());
				end else begin
					offer(3'($urandom_range(CMD_NONE, OP_UNUSED)), 8'($urandom), line_pick());
				end
			end
		end

		finish_busy();
		drain();
		repeat (10) @(posedge clk);
		if (chk_fails == 0) begin
			$display("one_wire_bus_master_unit_tb: PASS");
		end else begin
			$display("one_wire_bus_master_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/owbm_pkg.sv
src/owbm_front.sv
src/owbm_back.sv
src/one_wire_bus_master_unit.sv
src/owbm_checker.sv
bench/owbm_tick_checker.sv
bench/one_wire_bus_master_unit_tb.sv
